### design/brcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// brcc_pkg
// Shared types, register indexes and arithmetic helpers for the cascaded
// balance controller.
// ---------------------------------------------------------------------------
package brcc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ZERO_ANGLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_GAIN_P  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_GAIN_D  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN_P  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN_I  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN_P  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_DAMPING = 3'd7;

	localparam logic signed [16:0] RST_ZERO_ANGLE    = -17'sd154;
	localparam logic signed [31:0] RST_PITCH_GAIN_P  = 32'sd15728640;
	localparam logic signed [31:0] RST_PITCH_GAIN_D  = 32'sd65536;
	localparam logic signed [31:0] RST_SPEED_GAIN_P  = -32'sd22610;
	localparam logic signed [31:0] RST_SPEED_GAIN_I  = -32'sd113;
	localparam logic [16:0]        RST_FILTER_WEIGHT = 17'd45875;
	localparam logic signed [31:0] RST_STEER_GAIN_P  = 32'sd983040;
	localparam logic signed [31:0] RST_STEER_DAMPING = 32'sd42598;

	localparam logic signed [8:0]  FWD_LIMIT  = 9'sd70;
	localparam logic signed [8:0]  TURN_LIMIT = 9'sd90;
	localparam logic signed [8:0]  TURN_STEP  = 9'sd40;
	localparam logic signed [20:0] INT_LIMIT  = 21'sd10000;
	localparam logic [16:0]        WEIGHT_ONE = 17'd65536;

	localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
	localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

	typedef enum logic [2:0] {
		MS_FILT_NEW,
		MS_FILT_OLD,
		MS_SPD_P,
		MS_SPD_I,
		MS_PITCH_P,
		MS_PITCH_D,
		MS_STEER_P,
		MS_STEER_D
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_ADD_SHL8
	} acc_op_t;

	typedef struct packed {
		logic     capture;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     wr_filt;
		logic     wr_speed;
		logic     wr_perr;
		logic     wr_pitch;
		logic     wr_out;
	} cmd_t;

	// divide by 2^sh, rounding toward zero
	function automatic logic signed [65:0] shr_trunc(input logic signed [65:0] v,
			input int unsigned sh);
		logic signed [65:0] bias;
		bias = (66'sd1 <<< sh) - 66'sd1;
		return v[65] ? ((v + bias) >>> sh) : (v >>> sh);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7fffffff;
		end else if (v < SAT_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### design/brcc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// brcc_ctrl
// Sequencer: walks one control tick through the shared multiplier and
// accumulator, and owns the input and output handshakes.
// ---------------------------------------------------------------------------
module brcc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	output brcc_pkg::cmd_t     cmd
);
	import brcc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_F0, ST_F1, ST_F2, ST_F3,
		ST_S0, ST_S1, ST_S2, ST_S3,
		ST_P0, ST_P1, ST_P2, ST_P3, ST_P4,
		ST_T0, ST_T1, ST_T2
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MS_FILT_NEW;
		cmd.acc_op  = ACC_HOLD;
		case (state_q)
			ST_IDLE: cmd.capture = in_valid;
			ST_F0: cmd.mul_sel = MS_FILT_NEW;
			ST_F1: begin
				cmd.acc_op  = ACC_LOAD;
				cmd.mul_sel = MS_FILT_OLD;
			end
			ST_F2: cmd.acc_op = ACC_ADD;
			ST_F3: cmd.wr_filt = 1'b1;
			ST_S0: cmd.mul_sel = MS_SPD_P;
			ST_S1: begin
				cmd.acc_op  = ACC_LOAD;
				cmd.mul_sel = MS_SPD_I;
			end
			ST_S2: cmd.acc_op = ACC_ADD;
			ST_S3: cmd.wr_speed = 1'b1;
			ST_P0: cmd.wr_perr = 1'b1;
			ST_P1: cmd.mul_sel = MS_PITCH_P;
			ST_P2: begin
				cmd.acc_op  = ACC_LOAD;
				cmd.mul_sel = MS_PITCH_D;
			end
			ST_P3: cmd.acc_op = ACC_ADD_SHL8;
			ST_P4: begin
				cmd.wr_pitch = 1'b1;
				cmd.mul_sel  = MS_STEER_P;
			end
			ST_T0: begin
				cmd.acc_op  = ACC_LOAD;
				cmd.mul_sel = MS_STEER_D;
			end
			ST_T1: cmd.acc_op = ACC_ADD;
			ST_T2: cmd.wr_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_F0;
				ST_F0: state_q <= ST_F1;
				ST_F1: state_q <= ST_F2;
				ST_F2: state_q <= ST_F3;
				ST_F3: state_q <= ST_S0;
				ST_S0: state_q <= ST_S1;
				ST_S1: state_q <= ST_S2;
				ST_S2: state_q <= ST_S3;
				ST_S3: state_q <= ST_P0;
				ST_P0: state_q <= ST_P1;
				ST_P1: state_q <= ST_P2;
				ST_P2: state_q <= ST_P3;
				ST_P3: state_q <= ST_P4;
				ST_P4: state_q <= ST_T0;
				ST_T0: state_q <= ST_T1;
				ST_T1: state_q <= ST_T2;
				ST_T2: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### design/brcc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// brcc_datapath
// Configuration registers, loop state, one shared 33x32 multiplier with a
// product register, an accumulator, and the output registers.
// ---------------------------------------------------------------------------
module brcc_datapath #(
	parameter int DRIVE_LIMIT = 7200
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire brcc_pkg::cmd_t                      cmd,
	input  wire logic                                cfg_we,
	input  wire logic [brcc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [brcc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic signed [15:0]                  wheel_left,
	input  wire logic signed [15:0]                  wheel_right,
	input  wire logic signed [16:0]                  pitch_angle,
	input  wire logic signed [15:0]                  rate_pitch,
	input  wire logic signed [15:0]                  rate_yaw,
	input  wire logic                                go_forward,
	input  wire logic                                go_backward,
	input  wire logic                                steer_left,
	input  wire logic                                steer_right,
	input  wire logic                                clear_integral,
	output logic signed [15:0]                       drive_left,
	output logic signed [15:0]                       drive_right,
	output logic signed [31:0]                       speed_term,
	output logic signed [31:0]                       steer_term
);
	import brcc_pkg::*;

	localparam logic signed [32:0] LIMIT = 33'(DRIVE_LIMIT);

	// configuration
	logic signed [16:0] zero_angle_q;
	logic signed [31:0] pitch_gain_p_q, pitch_gain_d_q;
	logic signed [31:0] speed_gain_p_q, speed_gain_i_q;
	logic [16:0]        filter_weight_q;
	logic signed [31:0] steer_gain_p_q, steer_damping_q;

	// loop state
	logic signed [7:0]  fwd_target_q, turn_target_q;
	logic signed [19:0] filt_err_q;
	logic signed [14:0] err_int_q;

	// per-tick operands
	logic signed [17:0] err_q;
	logic signed [16:0] pitch_q;
	logic signed [15:0] gyro_pitch_q, gyro_yaw_q;
	logic               damp_on_q, clear_q;
	logic signed [31:0] speed_q, perr_q, pitch_term_q;

	logic signed [64:0] prod_q;
	logic signed [65:0] acc_q;

	logic signed [15:0] drive_left_q, drive_right_q;
	logic signed [31:0] speed_out_q, steer_out_q;

	// target ramps
	logic signed [8:0]  fwd_sum, fwd_next9, turn_sum, turn_next9;
	logic signed [7:0]  fwd_next, turn_next;
	logic signed [17:0] err_next;

	always_comb begin
		fwd_sum = {fwd_target_q[7], fwd_target_q}
			- (go_forward ? 9'sd1 : 9'sd0) + (go_backward ? 9'sd1 : 9'sd0);
		if (!go_forward && !go_backward) fwd_sum = 9'sd0;
		if (fwd_sum > FWD_LIMIT) begin
			fwd_next9 = FWD_LIMIT;
		end else if (fwd_sum < -FWD_LIMIT) begin
			fwd_next9 = -FWD_LIMIT;
		end else begin
			fwd_next9 = fwd_sum;
		end
		fwd_next = fwd_next9[7:0];

		turn_sum = {turn_target_q[7], turn_target_q}
			- (steer_left ? TURN_STEP : 9'sd0) + (steer_right ? TURN_STEP : 9'sd0);
		if (!steer_left && !steer_right) turn_sum = 9'sd0;
		if (turn_sum > TURN_LIMIT) begin
			turn_next9 = TURN_LIMIT;
		end else if (turn_sum < -TURN_LIMIT) begin
			turn_next9 = -TURN_LIMIT;
		end else begin
			turn_next9 = turn_sum;
		end
		turn_next = turn_next9[7:0];

		err_next = {{2{wheel_left[15]}}, wheel_left} + {{2{wheel_right[15]}}, wheel_right}
			- {{10{fwd_next[7]}}, fwd_next};
	end

	// multiplier operand select
	logic [16:0]        weight_sat;
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;

	assign weight_sat = filter_weight_q[16] ? WEIGHT_ONE : filter_weight_q;

	always_comb begin
		case (cmd.mul_sel)
			MS_FILT_NEW: begin
				mul_a = {16'b0, WEIGHT_ONE - weight_sat};
				mul_b = {{14{err_q[17]}}, err_q};
			end
			MS_FILT_OLD: begin
				mul_a = {16'b0, weight_sat};
				mul_b = {{12{filt_err_q[19]}}, filt_err_q};
			end
			MS_SPD_P: begin
				mul_a = {speed_gain_p_q[31], speed_gain_p_q};
				mul_b = {{12{filt_err_q[19]}}, filt_err_q};
			end
			MS_SPD_I: begin
				mul_a = {speed_gain_i_q[31], speed_gain_i_q};
				mul_b = {{17{err_int_q[14]}}, err_int_q};
			end
			MS_PITCH_P: begin
				mul_a = {pitch_gain_p_q[31], pitch_gain_p_q};
				mul_b = perr_q;
			end
			MS_PITCH_D: begin
				mul_a = {pitch_gain_d_q[31], pitch_gain_d_q};
				mul_b = {{16{gyro_pitch_q[15]}}, gyro_pitch_q};
			end
			MS_STEER_P: begin
				mul_a = {steer_gain_p_q[31], steer_gain_p_q};
				mul_b = {{24{turn_target_q[7]}}, turn_target_q};
			end
			MS_STEER_D: begin
				mul_a = damp_on_q ? {steer_damping_q[31], steer_damping_q} : 33'sd0;
				mul_b = {{16{gyro_yaw_q[15]}}, gyro_yaw_q};
			end
			default: begin
				mul_a = 33'sd0;
				mul_b = 32'sd0;
			end
		endcase
	end

	// results taken off the accumulator
	logic signed [65:0] prod_ext, acc_q16, acc_q24;
	logic signed [19:0] filt_next;
	logic signed [20:0] int_sum;
	logic signed [14:0] int_next;
	logic signed [41:0] perr_wide;
	logic signed [31:0] steer_now;
	logic signed [32:0] mix_l, mix_r;
	logic signed [32:0] drv_l, drv_r;

	always_comb begin
		prod_ext = {prod_q[64], prod_q};
		acc_q16  = shr_trunc(acc_q, 16);
		acc_q24  = shr_trunc(acc_q, 24);
		filt_next = acc_q16[19:0];

		int_sum = {{6{err_int_q[14]}}, err_int_q} + {filt_next[19], filt_next};
		if (clear_q) begin
			int_next = 15'sd0;
		end else if (int_sum > INT_LIMIT) begin
			int_next = INT_LIMIT[14:0];
		end else if (int_sum < -INT_LIMIT) begin
			int_next = 15'(-INT_LIMIT);
		end else begin
			int_next = int_sum[14:0];
		end

		perr_wide = {{25{pitch_q[16]}}, pitch_q}
			- (({{10{speed_q[31]}}, speed_q} <<< 8) + {{25{zero_angle_q[16]}}, zero_angle_q});

		steer_now = sat32(acc_q16);
		mix_l = {pitch_term_q[31], pitch_term_q} - {steer_now[31], steer_now};
		mix_r = {pitch_term_q[31], pitch_term_q} + {steer_now[31], steer_now};
		drv_l = (mix_l > LIMIT) ? LIMIT : ((mix_l < -LIMIT) ? -LIMIT : mix_l);
		drv_r = (mix_r > LIMIT) ? LIMIT : ((mix_r < -LIMIT) ? -LIMIT : mix_r);
	end

	// configuration and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_angle_q    <= RST_ZERO_ANGLE;
			pitch_gain_p_q  <= RST_PITCH_GAIN_P;
			pitch_gain_d_q  <= RST_PITCH_GAIN_D;
			speed_gain_p_q  <= RST_SPEED_GAIN_P;
			speed_gain_i_q  <= RST_SPEED_GAIN_I;
			filter_weight_q <= RST_FILTER_WEIGHT;
			steer_gain_p_q  <= RST_STEER_GAIN_P;
			steer_damping_q <= RST_STEER_DAMPING;
			fwd_target_q    <= 8'sd0;
			turn_target_q   <= 8'sd0;
			filt_err_q      <= 20'sd0;
			err_int_q       <= 15'sd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ZERO_ANGLE:    zero_angle_q    <= cfg_data[16:0];
					REG_PITCH_GAIN_P:  pitch_gain_p_q  <= cfg_data;
					REG_PITCH_GAIN_D:  pitch_gain_d_q  <= cfg_data;
					REG_SPEED_GAIN_P:  speed_gain_p_q  <= cfg_data;
					REG_SPEED_GAIN_I:  speed_gain_i_q  <= cfg_data;
					REG_FILTER_WEIGHT: filter_weight_q <= cfg_data[16:0];
					REG_STEER_GAIN_P:  steer_gain_p_q  <= cfg_data;
					REG_STEER_DAMPING: steer_damping_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.capture) begin
				fwd_target_q  <= fwd_next;
				turn_target_q <= turn_next;
			end
			if (cmd.wr_filt) begin
				filt_err_q <= filt_next;
				err_int_q  <= int_next;
			end
		end
	end

	// per-tick payload, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.acc_op)
			ACC_LOAD:     acc_q <= prod_ext;
			ACC_ADD:      acc_q <= acc_q + prod_ext;
			ACC_ADD_SHL8: acc_q <= acc_q + (prod_ext <<< 8);
			default:      acc_q <= acc_q;
		endcase
		if (cmd.capture) begin
			err_q        <= err_next;
			pitch_q      <= pitch_angle;
			gyro_pitch_q <= rate_pitch;
			gyro_yaw_q   <= rate_yaw;
			damp_on_q    <= !steer_left && !steer_right;
			clear_q      <= clear_integral;
		end
		if (cmd.wr_speed) speed_q <= sat32(acc_q16);
		if (cmd.wr_perr) perr_q <= sat32({{24{perr_wide[41]}}, perr_wide});
		if (cmd.wr_pitch) pitch_term_q <= sat32(acc_q24);
		if (cmd.wr_out) begin
			drive_left_q  <= drv_l[15:0];
			drive_right_q <= drv_r[15:0];
			speed_out_q   <= speed_q;
			steer_out_q   <= steer_now;
		end
	end

	assign drive_left  = drive_left_q;
	assign drive_right = drive_right_q;
	assign speed_term  = speed_out_q;
	assign steer_term  = steer_out_q;

endmodule
`default_nettype wire

### design/balance_robot_cascade_controller_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// balance_robot_cascade_controller_unit
// Cascaded speed PI / pitch PD / turn controller for a two-wheel balancer,
// one control tick per input transfer.
// ---------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_stall    encoder counts, pitch, gyro rates, buttons
//  out      out_valid/out_stall  drive_left/right, speed_term, steer_term
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  In a tick, eight products go one at a time through the single 33x32
//  multiplier and its accumulator. The result sits in an output register;
//  the next tick can be taken in the cycle after that register is loaded.
//  A tick waits only if the previous result is still stalled when the new
//  one is ready. Reset restores the register defaults and clears the
//  targets, filter and integral.
// ---------------------------------------------------------------------------
module balance_robot_cascade_controller_unit #(
	parameter int DRIVE_LIMIT = 7200
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [brcc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [brcc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic signed [15:0]               wheel_left,
	input  wire logic signed [15:0]               wheel_right,
	input  wire logic signed [16:0]               pitch_angle,
	input  wire logic signed [15:0]               rate_pitch,
	input  wire logic signed [15:0]               rate_yaw,
	input  wire logic                             go_forward,
	input  wire logic                             go_backward,
	input  wire logic                             steer_left,
	input  wire logic                             steer_right,
	input  wire logic                             clear_integral,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [15:0]                    drive_left,
	output logic signed [15:0]                    drive_right,
	output logic signed [31:0]                    speed_term,
	output logic signed [31:0]                    steer_term
);
	import brcc_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	brcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	brcc_datapath #(
		.DRIVE_LIMIT (DRIVE_LIMIT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.wheel_left     (wheel_left),
		.wheel_right    (wheel_right),
		.pitch_angle    (pitch_angle),
		.rate_pitch     (rate_pitch),
		.rate_yaw       (rate_yaw),
		.go_forward     (go_forward),
		.go_backward    (go_backward),
		.steer_left     (steer_left),
		.steer_right    (steer_right),
		.clear_integral (clear_integral),
		.drive_left     (drive_left),
		.drive_right    (drive_right),
		.speed_term     (speed_term),
		.steer_term     (steer_term)
	);

endmodule
`default_nettype wire

### test/balance_robot_cascade_controller_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// balance_robot_cascade_controller_unit_tb
// Drives control ticks through the balance controller under random input
// gaps and output stalls. Every tick is predicted in the bench (targets,
// speed PI, pitch PD, turn term, mixing) and each result transfer is checked
// field by field. Register settings change between phases while idle.
// ---------------------------------------------------------------------------
module balance_robot_cascade_controller_unit_tb;
	import brcc_pkg::*;

	localparam int DRIVE_LIMIT = 7200;
	localparam int NUM_PHASES = 8;
	localparam int LAST_PHASE = NUM_PHASES - 1;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam longint FWD_MAX = 70;
	localparam longint TURN_MAX = 90;
	localparam longint TURN_STEP_SZ = 40;
	localparam longint INTEG_MAX = 10000;
	localparam longint Q16 = 65536;
	localparam longint Q24 = 16777216;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	// button mask layout {fwd, bwd, left, right, clear}
	localparam logic [4:0] BTN_FWD   = 5'b10000;
	localparam logic [4:0] BTN_BWD   = 5'b01000;
	localparam logic [4:0] BTN_LEFT  = 5'b00100;
	localparam logic [4:0] BTN_RIGHT = 5'b00010;
	localparam logic [4:0] BTN_CLR   = 5'b00001;

	typedef struct {
		logic signed [15:0] wl;
		logic signed [15:0] wr;
		logic signed [16:0] pitch;
		logic signed [15:0] gp;
		logic signed [15:0] gy;
		logic [4:0]         btn;
	} tick_in_t;

	typedef struct {
		logic signed [15:0] dl;
		logic signed [15:0] dr;
		logic signed [31:0] spd;
		logic signed [31:0] steer;
	} drive_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] wheel_left = '0;
	logic signed [15:0] wheel_right = '0;
	logic signed [16:0] pitch_angle = '0;
	logic signed [15:0] rate_pitch = '0;
	logic signed [15:0] rate_yaw = '0;
	logic               go_forward = 1'b0;
	logic               go_backward = 1'b0;
	logic               steer_left = 1'b0;
	logic               steer_right = 1'b0;
	logic               clear_integral = 1'b0;

	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] drive_left;
	logic signed [15:0] drive_right;
	logic signed [31:0] speed_term;
	logic signed [31:0] steer_term;

	balance_robot_cascade_controller_unit #(
		.DRIVE_LIMIT(DRIVE_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.wheel_left(wheel_left),
		.wheel_right(wheel_right),
		.pitch_angle(pitch_angle),
		.rate_pitch(rate_pitch),
		.rate_yaw(rate_yaw),
		.go_forward(go_forward),
		.go_backward(go_backward),
		.steer_left(steer_left),
		.steer_right(steer_right),
		.clear_integral(clear_integral),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive_left(drive_left),
		.drive_right(drive_right),
		.speed_term(speed_term),
		.steer_term(steer_term)
	);

	always #6 clk = ~clk;

	// bench copy of the register file
	logic signed [16:0] set_zero;
	logic signed [31:0] set_pitch_p, set_pitch_d, set_speed_p, set_speed_i;
	logic [16:0]        set_weight;
	logic signed [31:0] set_steer_p, set_steer_d;

	// bench copy of controller state
	longint fwd_tgt, turn_tgt, filt_err, err_integ;

	tick_in_t      pending_ticks[$];
	drive_result_t expected_drive_q[$];
	tick_in_t      cur_tick;
	drive_result_t want;

	int  error_count = 0;
	int  in_gap_left = 0;
	int  out_stall_left = 0;
	bit  in_calm = 1'b0;
	bit  out_calm = 1'b0;
	int  idle_cycles = 0;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint clip32(input longint v);
		return clip(v, S32_MIN, S32_MAX);
	endfunction

	function automatic int srand(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// mostly short gaps, a few long ones; none during a calm stretch
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic control_tick(input tick_in_t t);
		longint w, err, damp, spd, perr, pterm, steer, dl, dr;
		drive_result_t r;
		if (t.btn & BTN_FWD) fwd_tgt -= 1;
		if (t.btn & BTN_BWD) fwd_tgt += 1;
		if (!(t.btn & (BTN_FWD | BTN_BWD))) fwd_tgt = 0;
		fwd_tgt = clip(fwd_tgt, -FWD_MAX, FWD_MAX);

		if (t.btn & BTN_LEFT) turn_tgt -= TURN_STEP_SZ;
		if (t.btn & BTN_RIGHT) turn_tgt += TURN_STEP_SZ;
		if (!(t.btn & (BTN_LEFT | BTN_RIGHT))) begin
			turn_tgt = 0;
			damp = longint'(set_steer_d);
		end else begin
			damp = 0;
		end
		turn_tgt = clip(turn_tgt, -TURN_MAX, TURN_MAX);

		w = set_weight;
		if (w > Q16) w = Q16;
		err = longint'(t.wl) + longint'(t.wr) - fwd_tgt;
		filt_err = ((Q16 - w) * err + w * filt_err) / Q16;
		err_integ = clip(err_integ + filt_err, -INTEG_MAX, INTEG_MAX);
		if (t.btn & BTN_CLR) err_integ = 0;
		spd = clip32((longint'(set_speed_p) * filt_err
			+ longint'(set_speed_i) * err_integ) / Q16);

		perr = clip32(longint'(t.pitch) - (spd * 256 + longint'(set_zero)));
		pterm = clip32((longint'(set_pitch_p) * perr
			+ longint'(set_pitch_d) * longint'(t.gp) * 256) / Q24);
		steer = clip32((longint'(set_steer_p) * turn_tgt + damp * longint'(t.gy)) / Q16);

		dl = clip(pterm - steer, -DRIVE_LIMIT, DRIVE_LIMIT);
		dr = clip(pterm + steer, -DRIVE_LIMIT, DRIVE_LIMIT);
		r.dl = dl[15:0];
		r.dr = dr[15:0];
		r.spd = spd[31:0];
		r.steer = steer[31:0];
		expected_drive_q.push_back(r);
	endtask

	task automatic add_tick(input int wl, input int wr, input int pitch, input int gp,
			input int gy, input logic [4:0] btn);
		tick_in_t t;
		t.wl = 16'(wl);
		t.wr = 16'(wr);
		t.pitch = 17'(pitch);
		t.gp = 16'(gp);
		t.gy = 16'(gy);
		t.btn = btn;
		pending_ticks.push_back(t);
	endtask

	// buttons held for runs (long enough to hit the target clamps), encoder drift
	// per run so the integral can saturate, with some full-range noise
	task automatic add_random_ticks(input int n);
		int hold, bias, wl, wr, pitch, gp, gy;
		logic [4:0] held_btn, btn;
		hold = 0;
		bias = 0;
		held_btn = '0;
		repeat (n) begin
			if (hold == 0) begin
				case ($urandom_range(0, 7))
					0: held_btn = '0;
					1: held_btn = BTN_FWD;
					2: held_btn = BTN_BWD;
					3: held_btn = BTN_FWD | BTN_LEFT;
					4: held_btn = BTN_BWD | BTN_RIGHT;
					5: held_btn = BTN_LEFT;
					6: held_btn = BTN_RIGHT;
					default: held_btn = 5'($urandom_range(0, 15)) << 1;
				endcase
				hold = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 100)
					: $urandom_range(1, 20);
				bias = srand(100);
			end
			hold--;
			btn = held_btn;
			if ($urandom_range(0, 14) == 0) btn ^= BTN_CLR << $urandom_range(1, 4);
			if ($urandom_range(0, 24) == 0) btn |= BTN_CLR;
			if ($urandom_range(0, 11) == 0) begin
				wl = $urandom;
				wr = $urandom;
			end else begin
				wl = bias / 2 + srand(8);
				wr = bias / 2 + srand(8);
			end
			pitch = ($urandom_range(0, 9) == 0) ? $urandom : srand(3000);
			gp = ($urandom_range(0, 7) == 0) ? $urandom : srand(3000);
			gy = ($urandom_range(0, 7) == 0) ? $urandom : srand(3000);
			add_tick(wl, wr, pitch, gp, gy, btn);
		end
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_ZERO_ANGLE:    set_zero = val[16:0];
			REG_PITCH_GAIN_P:  set_pitch_p = val;
			REG_PITCH_GAIN_D:  set_pitch_d = val;
			REG_SPEED_GAIN_P:  set_speed_p = val;
			REG_SPEED_GAIN_I:  set_speed_i = val;
			REG_FILTER_WEIGHT: set_weight = val[16:0];
			REG_STEER_GAIN_P:  set_steer_p = val;
			REG_STEER_DAMPING: set_steer_d = val;
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int ph);
		logic [31:0] val [8];
		logic [31:0] dflt [8];
		dflt[REG_ZERO_ANGLE] = 32'(RST_ZERO_ANGLE);
		dflt[REG_PITCH_GAIN_P] = RST_PITCH_GAIN_P;
		dflt[REG_PITCH_GAIN_D] = RST_PITCH_GAIN_D;
		dflt[REG_SPEED_GAIN_P] = RST_SPEED_GAIN_P;
		dflt[REG_SPEED_GAIN_I] = RST_SPEED_GAIN_I;
		dflt[REG_FILTER_WEIGHT] = 32'(RST_FILTER_WEIGHT);
		dflt[REG_STEER_GAIN_P] = RST_STEER_GAIN_P;
		dflt[REG_STEER_DAMPING] = RST_STEER_DAMPING;
		for (int k = 0; k < 8; k++) begin
			case (ph)
				1: val[k] = 32'h7fff_ffff;
				2: val[k] = 32'h8000_0000;
				LAST_PHASE: val[k] = dflt[k];
				default: val[k] = ($urandom_range(0, 3) == 0) ? $urandom
					: dflt[k] * 32'(srand(3));
			endcase
		end
		case (ph)
			1: begin
				val[REG_ZERO_ANGLE] = 65535;
				val[REG_FILTER_WEIGHT] = 0;
			end
			2: begin
				val[REG_ZERO_ANGLE] = -65536;
				val[REG_FILTER_WEIGHT] = 131071;
			end
			3: begin
				val[REG_ZERO_ANGLE] = 46080;
				val[REG_FILTER_WEIGHT] = 65536;
			end
			4: begin
				val[REG_ZERO_ANGLE] = -46080;
				val[REG_FILTER_WEIGHT] = $urandom_range(0, 65536);
			end
			LAST_PHASE: ;
			default: begin
				val[REG_ZERO_ANGLE] = srand(46080);
				val[REG_FILTER_WEIGHT] = ($urandom_range(0, 7) == 0)
					? $urandom_range(65537, 131071) : $urandom_range(0, 65536);
			end
		endcase
		for (int k = 0; k < 8; k++) write_reg(CFG_IDX_W'(k), val[k]);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_ticks.size() != 0 || expected_drive_q.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			error_count++;
		end
	endtask

	// tick driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) control_tick(cur_tick);
			if (!in_valid || !in_stall) begin
				if (in_gap_left > 0) begin
					in_valid <= 1'b0;
					in_gap_left--;
				end else if (pending_ticks.size() != 0) begin
					cur_tick = pending_ticks.pop_front();
					in_valid <= 1'b1;
					wheel_left <= cur_tick.wl;
					wheel_right <= cur_tick.wr;
					pitch_angle <= cur_tick.pitch;
					rate_pitch <= cur_tick.gp;
					rate_yaw <= cur_tick.gy;
					go_forward <= |(cur_tick.btn & BTN_FWD);
					go_backward <= |(cur_tick.btn & BTN_BWD);
					steer_left <= |(cur_tick.btn & BTN_LEFT);
					steer_right <= |(cur_tick.btn & BTN_RIGHT);
					clear_integral <= |(cur_tick.btn & BTN_CLR);
					if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
					in_gap_left = pick_gap(in_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and stall generator
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_drive_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
						$time, drive_left, drive_right, speed_term, steer_term);
					error_count++;
				end else begin
					want = expected_drive_q.pop_front();
					check_field("drive_left", want.dl, drive_left);
					check_field("drive_right", want.dr, drive_right);
					check_field("speed_term", want.spd, speed_term);
					check_field("steer_term", want.steer, steer_term);
				end
			end
			if (out_stall_left > 0) begin
				out_stall <= 1'b1;
				out_stall_left--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
				out_stall_left = pick_gap(out_calm);
			end
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				expected_drive_q.size());
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		set_zero = RST_ZERO_ANGLE;
		set_pitch_p = RST_PITCH_GAIN_P;
		set_pitch_d = RST_PITCH_GAIN_D;
		set_speed_p = RST_SPEED_GAIN_P;
		set_speed_i = RST_SPEED_GAIN_I;
		set_weight = RST_FILTER_WEIGHT;
		set_steer_p = RST_STEER_GAIN_P;
		set_steer_d = RST_STEER_DAMPING;
		fwd_tgt = 0;
		turn_tgt = 0;
		filt_err = 0;
		err_integ = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// field extremes, every button combination of interest
		add_tick(0, 0, 0, 0, 0, '0);
		add_tick(32767, 32767, 46080, 32767, 32767, '0);
		add_tick(-32768, -32768, -46080, -32768, -32768, '0);
		add_tick(32767, -32768, 65535, 0, 0, BTN_CLR);
		add_tick(-1, 1, -65536, 1, -1, BTN_FWD);
		add_tick(5, 3, -154, 100, -100, BTN_FWD | BTN_BWD);
		add_tick(0, 0, 0, 0, 0, BTN_BWD);
		add_tick(0, 0, 256, 0, 500, BTN_BWD);
		add_tick(0, 0, 0, 0, 1000, BTN_LEFT);
		add_tick(0, 0, 0, 0, 1000, BTN_LEFT);
		add_tick(0, 0, 0, 0, 1000, BTN_LEFT);
		add_tick(0, 0, 0, 0, -1000, BTN_RIGHT);
		add_tick(0, 0, 0, 0, -1000, BTN_LEFT | BTN_RIGHT);
		add_tick(0, 0, 0, 0, -1000, BTN_RIGHT);
		add_tick(0, 0, 0, 0, -1000, BTN_RIGHT);
		add_tick(0, 0, 0, 0, -1000, BTN_RIGHT);
		add_tick(12, -7, -300, -2000, 32767, '0);
		add_tick(100, 100, 0, 0, 0, BTN_FWD | BTN_BWD | BTN_LEFT | BTN_RIGHT | BTN_CLR);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph != 0) begin
				wait_idle();
				apply_setting(ph);
			end
			add_random_ticks(ph == 0 ? 200 : (ph < 3 ? 40 : 70));
		end
		wait_idle();
		repeat (40) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### balance_robot_cascade_controller_unit.f
design/brcc_pkg.sv
design/brcc_ctrl.sv
design/brcc_datapath.sv
design/balance_robot_cascade_controller_unit.sv
test/balance_robot_cascade_controller_unit_tb.sv
